[hdl/ple_pkg.sv]
package ple_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // position and count compares are done at this width (holds 0..256 and 255+1)
    localparam int PLE_IW = 9;

    localparam int OPCODE_W = 3;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int DOUT_W   = 32;
    localparam int FPOS_W   = 8;
    localparam int LEN_W    = 5;

    localparam logic [OPCODE_W-1:0] OP_INSERT_AT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_DELETE_AT = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_READ_AT   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_INS_HEAD  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_INS_TAIL  = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_LOCATE    = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_CLEAR     = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // broadcast from the control to every cell
    typedef struct packed {
        logic              ins;        // open a gap at idx, write value there
        logic              del;        // close the gap at idx
        logic              load_hit;   // capture compare result
        logic              shift_hit;  // move hit bits one cell toward the head
        logic [PLE_IW-1:0] idx;
        logic [PLE_IW-1:0] count;
    } t_cell_ctl;

endpackage

[hdl/ple_cell.sv]
module ple_cell #(
    parameter int DATA_WIDTH = ple_pkg::DEF_DATA_WIDTH,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ple_pkg::t_cell_ctl    i_ctl,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left_data,
    input  logic [DATA_WIDTH-1:0] i_right_data,
    input  logic                  i_right_hit,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_hit,
    output logic [DATA_WIDTH-1:0] o_tap
);

    localparam int IW = ple_pkg::PLE_IW;
    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  r_hit;
    logic                  n_hit;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (MY_IDX == i_ctl.idx) begin
                n_data = i_value;
            end else if (MY_IDX > i_ctl.idx) begin
                n_data = i_left_data;
            end
        end else if (i_ctl.del && (MY_IDX >= i_ctl.idx)) begin
            n_data = i_right_data;
        end
    end

    always_comb begin
        n_hit = r_hit;
        if (i_ctl.load_hit) begin
            n_hit = (r_data == i_value) && (MY_IDX < i_ctl.count);
        end else if (i_ctl.shift_hit) begin
            n_hit = i_right_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;
    assign o_tap  = (MY_IDX == i_ctl.idx) ? r_data : '0;

endmodule

[hdl/positional_list_engine.sv]
// For every opcode but locate, the result is registered in the cycle after the input transfer.
// Locate: the hit bits walk the cell chain one cell a cycle until a hit reaches the head or the list ends.
// Throughput: one item per cycle unless the output stalls or a locate scan is running.
// Reset clears the length, the scan state and the output valid flag; stored
// words are not cleared and are only read below the current length.
module positional_list_engine #(
    parameter int CAPACITY   = ple_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = ple_pkg::DEF_DATA_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // position[7:0], value[39:8]
    input  logic [2:0]  s_axis_tuser,   // opcode[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // data_out[31:0], found_position[39:32],
                                        // list_length[44:40], zero pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int IW    = ple_pkg::PLE_IW;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] CAP_I = IW'(CAPACITY);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic [ple_pkg::OPCODE_W-1:0] w_op;
    logic [ple_pkg::POS_W-1:0]    w_pos;
    logic [ple_pkg::VALUE_W-1:0]  w_val_in;
    logic [63:0]                  w_val64;
    logic [DATA_WIDTH-1:0]        w_value;

    assign w_pos    = s_axis_tdata[7:0];
    assign w_val_in = s_axis_tdata[39:8];
    assign w_op     = s_axis_tuser;
    assign w_val64  = 64'(w_val_in);
    assign w_value  = w_val64[DATA_WIDTH-1:0];

    logic              r_state;
    logic              n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  r_k;
    logic [CNT_W-1:0]  n_k;

    logic                         r_ovalid;
    logic                         n_ovalid;
    logic [ple_pkg::STATUS_W-1:0] r_status;
    logic [ple_pkg::STATUS_W-1:0] n_status;
    logic [ple_pkg::DOUT_W-1:0]   r_dout;
    logic [ple_pkg::DOUT_W-1:0]   n_dout;
    logic [ple_pkg::FPOS_W-1:0]   r_fpos;
    logic [ple_pkg::FPOS_W-1:0]   n_fpos;
    logic [ple_pkg::LEN_W-1:0]    r_len;
    logic [ple_pkg::LEN_W-1:0]    n_len;

    ple_pkg::t_cell_ctl w_ctl;

    logic [DATA_WIDTH-1:0] w_data [CAPACITY];
    logic [DATA_WIDTH-1:0] w_tap  [CAPACITY];
    logic                  w_hit  [CAPACITY];
    logic [DATA_WIDTH-1:0] w_rd;
    logic [63:0]           w_rd64;

    logic [IW-1:0] w_pos_i;
    logic [IW-1:0] w_cnt_i;
    logic [IW-1:0] w_k1;
    logic          w_out_free;
    logic          w_accept;
    logic          w_full;
    logic          w_ins_bad;
    logic          w_acc_bad;
    logic          w_scan_done;

    assign w_pos_i     = IW'(w_pos);
    assign w_cnt_i     = IW'(r_count);
    assign w_k1        = IW'(r_k) + IW'(1);
    assign w_out_free  = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_full      = (w_cnt_i >= CAP_I);
    assign w_ins_bad   = (w_pos_i == '0) || (w_pos_i > w_cnt_i + IW'(1));
    assign w_acc_bad   = (w_pos_i == '0) || (w_pos_i > w_cnt_i);
    assign w_scan_done = w_hit[0] || (w_k1 >= w_cnt_i);

    // read port over the chain: one-hot taps OR'ed together
    always_comb begin
        w_rd = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_rd = w_rd | w_tap[i];
        end
    end
    assign w_rd64 = 64'(w_rd);

    always_comb begin
        w_ctl.ins       = 1'b0;
        w_ctl.del       = 1'b0;
        w_ctl.load_hit  = 1'b0;
        w_ctl.shift_hit = 1'b0;
        w_ctl.count     = w_cnt_i;
        case (w_op)
            ple_pkg::OP_INS_HEAD: w_ctl.idx = '0;
            ple_pkg::OP_INS_TAIL: w_ctl.idx = w_cnt_i;
            default:              w_ctl.idx = w_pos_i - IW'(1);
        endcase

        n_state  = r_state;
        n_count  = r_count;
        n_k      = r_k;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_status = r_status;
        n_dout   = r_dout;
        n_fpos   = r_fpos;
        n_len    = r_len;

        if (r_state == S_SCAN) begin
            if (w_scan_done) begin
                if (w_out_free) begin
                    n_state  = S_IDLE;
                    n_ovalid = 1'b1;
                    n_status = w_hit[0] ? ple_pkg::ST_OK : ple_pkg::ST_NOT_FOUND;
                    n_dout   = '0;
                    n_fpos   = w_hit[0] ? w_k1[ple_pkg::FPOS_W-1:0] : '0;
                    n_len    = w_cnt_i[ple_pkg::LEN_W-1:0];
                end
            end else begin
                w_ctl.shift_hit = 1'b1;
                n_k             = r_k + CNT_W'(1);
            end
        end else if (w_accept) begin
            n_ovalid = 1'b1;
            n_status = ple_pkg::ST_OK;
            n_dout   = '0;
            n_fpos   = '0;
            case (w_op)
                ple_pkg::OP_INSERT_AT: begin
                    if (w_ins_bad) begin
                        n_status = ple_pkg::ST_BAD_POS;
                    end else if (w_full) begin
                        n_status = ple_pkg::ST_FULL;
                    end else begin
                        w_ctl.ins = 1'b1;
                        n_count   = r_count + CNT_W'(1);
                    end
                end
                ple_pkg::OP_INS_HEAD, ple_pkg::OP_INS_TAIL: begin
                    if (w_full) begin
                        n_status = ple_pkg::ST_FULL;
                    end else begin
                        w_ctl.ins = 1'b1;
                        n_count   = r_count + CNT_W'(1);
                    end
                end
                ple_pkg::OP_DELETE_AT: begin
                    if (w_acc_bad) begin
                        n_status = ple_pkg::ST_BAD_POS;
                    end else begin
                        w_ctl.del = 1'b1;
                        n_dout    = w_rd64[ple_pkg::DOUT_W-1:0];
                        n_count   = r_count - CNT_W'(1);
                    end
                end
                ple_pkg::OP_READ_AT: begin
                    if (w_acc_bad) begin
                        n_status = ple_pkg::ST_BAD_POS;
                    end else begin
                        n_dout = w_rd64[ple_pkg::DOUT_W-1:0];
                    end
                end
                ple_pkg::OP_LOCATE: begin
                    // result comes out of the scan
                    n_ovalid       = 1'b0;
                    w_ctl.load_hit = 1'b1;
                    n_k            = '0;
                    n_state        = S_SCAN;
                end
                ple_pkg::OP_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                end
            endcase
            n_len = ple_pkg::LEN_W'(n_count);
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_left;
            logic [DATA_WIDTH-1:0] w_right;
            logic                  w_rhit;
            if (g == 0) begin : g_head
                assign w_left = w_value;
            end else begin : g_mid_l
                assign w_left = w_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign w_right = w_data[g];
                assign w_rhit  = 1'b0;
            end else begin : g_mid_r
                assign w_right = w_data[g+1];
                assign w_rhit  = w_hit[g+1];
            end
            ple_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .INDEX      (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_value      (w_value),
                .i_left_data  (w_left),
                .i_right_data (w_right),
                .i_right_hit  (w_rhit),
                .o_data       (w_data[g]),
                .o_hit        (w_hit[g]),
                .o_tap        (w_tap[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_k      <= n_k;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_dout   <= n_dout;
        r_fpos   <= n_fpos;
        r_len    <= n_len;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {3'b000, r_len, r_fpos, r_dout};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        IW'(r_count) <= CAP_I)
        else $error("list length above capacity");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (r_state == S_IDLE))
        else $error("input taken during a scan");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full && (w_op == ple_pkg::OP_INSERT_AT
            || w_op == ple_pkg::OP_INS_HEAD || w_op == ple_pkg::OP_INS_TAIL))
        |=> $stable(r_count))
        else $error("full list grew");

    a_locate_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == ple_pkg::OP_LOCATE)) |=> (r_state == S_SCAN) && (r_k == '0))
        else $error("locate did not start a scan");

    a_scan_shift_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !w_ctl.ins && !w_ctl.del)
        else $error("list changed during a scan");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int CAPACITY    = ple_pkg::DEF_CAPACITY;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ITEMS  = 1300;
    localparam logic [ple_pkg::OPCODE_W-1:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [ple_pkg::OPCODE_W-1:0] op;
        logic [ple_pkg::POS_W-1:0]    pos;
        logic [ple_pkg::VALUE_W-1:0]  val;
    } t_list_cmd;

    typedef struct packed {
        logic [ple_pkg::STATUS_W-1:0] status;
        logic [ple_pkg::DOUT_W-1:0]   data;
        logic [ple_pkg::FPOS_W-1:0]   fpos;
        logic [ple_pkg::LEN_W-1:0]    len;
    } t_list_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;    // position[7:0], value[39:8]
    logic [2:0]  s_axis_tuser = '0;    // opcode[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // data_out[31:0], found_position[39:32],
                                       // list_length[44:40], zero pad
    logic [1:0]  m_axis_tuser;         // status[1:0]

    positional_list_engine u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    t_list_cmd    pending_cmds[$];
    t_list_result expected_results[$];

    // shadow copy of the list contents
    logic [ple_pkg::VALUE_W-1:0] shadow_words[CAPACITY];
    int                          shadow_len = 0;

    // length tracked while the command stream is built
    int gen_len = 0;

    int cycle_count = 0;
    int items_accepted = 0;
    int total_items = -1;
    int mismatch_count = 0;
    logic in_taken = 1'b0;
    int burst_left = 1;
    int gap_left = 0;
    int ready_mode = 0;
    t_list_cmd drv_cmd;
    t_list_result want;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic void open_slot(int idx, logic [ple_pkg::VALUE_W-1:0] v);
        for (int k = shadow_len; k > idx; k--)
            shadow_words[k] = shadow_words[k-1];
        shadow_words[idx] = v;
        shadow_len++;
    endfunction

    function automatic t_list_result predict_list_op(logic [ple_pkg::OPCODE_W-1:0] op,
                                                     logic [ple_pkg::POS_W-1:0] pos,
                                                     logic [ple_pkg::VALUE_W-1:0] val);
        t_list_result r;
        int p;
        r = '0;
        r.status = ple_pkg::ST_OK;
        p = pos;
        case (op)
            ple_pkg::OP_INSERT_AT: begin
                // range check wins over the full check
                if (p < 1 || p > shadow_len + 1)
                    r.status = ple_pkg::ST_BAD_POS;
                else if (shadow_len >= CAPACITY)
                    r.status = ple_pkg::ST_FULL;
                else
                    open_slot(p - 1, val);
            end
            ple_pkg::OP_DELETE_AT: begin
                if (p < 1 || p > shadow_len) begin
                    r.status = ple_pkg::ST_BAD_POS;
                end else begin
                    r.data = shadow_words[p-1];
                    for (int k = p - 1; k + 1 < shadow_len; k++)
                        shadow_words[k] = shadow_words[k+1];
                    shadow_len--;
                end
            end
            ple_pkg::OP_READ_AT: begin
                if (p < 1 || p > shadow_len)
                    r.status = ple_pkg::ST_BAD_POS;
                else
                    r.data = shadow_words[p-1];
            end
            ple_pkg::OP_INS_HEAD, ple_pkg::OP_INS_TAIL: begin
                if (shadow_len >= CAPACITY)
                    r.status = ple_pkg::ST_FULL;
                else
                    open_slot((op == ple_pkg::OP_INS_HEAD) ? 0 : shadow_len, val);
            end
            ple_pkg::OP_LOCATE: begin
                r.status = ple_pkg::ST_NOT_FOUND;
                for (int k = 0; k < shadow_len; k++) begin
                    if (r.status == ple_pkg::ST_NOT_FOUND && shadow_words[k] == val) begin
                        r.status = ple_pkg::ST_OK;
                        r.fpos = ple_pkg::FPOS_W'(k + 1);
                    end
                end
            end
            ple_pkg::OP_CLEAR: shadow_len = 0;
            default: ;
        endcase
        r.len = ple_pkg::LEN_W'(shadow_len);
        return r;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic add_cmd(logic [ple_pkg::OPCODE_W-1:0] op, int pos,
                           logic [ple_pkg::VALUE_W-1:0] val);
        t_list_cmd c;
        c.op = op;
        c.pos = ple_pkg::POS_W'(pos);
        c.val = val;
        pending_cmds.push_back(c);
        case (op)
            ple_pkg::OP_INSERT_AT:
                if (pos >= 1 && pos <= gen_len + 1 && gen_len < CAPACITY) gen_len++;
            ple_pkg::OP_DELETE_AT:
                if (pos >= 1 && pos <= gen_len) gen_len--;
            ple_pkg::OP_INS_HEAD, ple_pkg::OP_INS_TAIL:
                if (gen_len < CAPACITY) gen_len++;
            ple_pkg::OP_CLEAR: gen_len = 0;
            default: ;
        endcase
    endtask

    // sender: bursts with random gaps, holds an item until its transfer
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_taken) begin
            // waiting for the transfer
        end else if (gap_left > 0 || pending_cmds.size() == 0) begin
            s_axis_tvalid <= 1'b0;
            if (gap_left > 0) gap_left--;
        end else begin
            drv_cmd = pending_cmds.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tuser <= drv_cmd.op;
            s_axis_tdata <= {drv_cmd.val, drv_cmd.pos};
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 16);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
    end

    // receiver: stall pattern is picked at random from four modes
    always @(negedge i_clk) begin
        if (cycle_count % 160 == 0)
            ready_mode = $urandom_range(0, 3);
        case (ready_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= (cycle_count % 8 != 3) && (cycle_count % 8 != 6);
            default: m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_results.push_back(predict_list_op(s_axis_tuser, s_axis_tdata[7:0],
                                                       s_axis_tdata[39:8]));
            items_accepted <= items_accepted + 1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser != want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_axis_tuser, want.status));
                if (m_axis_tdata[31:0] != want.data)
                    report_mismatch($sformatf("data_out got %h want %h",
                                              m_axis_tdata[31:0], want.data));
                if (m_axis_tdata[39:32] != want.fpos)
                    report_mismatch($sformatf("found_position got %0d want %0d",
                                              m_axis_tdata[39:32], want.fpos));
                if (m_axis_tdata[44:40] != want.len)
                    report_mismatch($sformatf("list_length got %0d want %0d",
                                              m_axis_tdata[44:40], want.len));
                if (m_axis_tdata[47:45] != '0)
                    report_mismatch($sformatf("pad bits got %b", m_axis_tdata[47:45]));
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("positional_list_engine test failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [ple_pkg::VALUE_W-1:0]  value_pool[8];
        logic [ple_pkg::OPCODE_W-1:0] op;
        logic [ple_pkg::VALUE_W-1:0]  val;
        int phase;
        int pick;
        int ins_w;
        int del_w;
        int pos;

        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h0000_0001;
        for (int k = 4; k < 8; k++)
            value_pool[k] = $urandom;

        // directed: empty list, range edges, head/tail, duplicates, unused opcode
        add_cmd(ple_pkg::OP_CLEAR,     0,   32'h0);
        add_cmd(ple_pkg::OP_READ_AT,   1,   32'h0);
        add_cmd(ple_pkg::OP_DELETE_AT, 1,   32'h0);
        add_cmd(ple_pkg::OP_LOCATE,    0,   32'h0);
        add_cmd(ple_pkg::OP_INSERT_AT, 0,   32'hDEAD_BEEF);
        add_cmd(ple_pkg::OP_INSERT_AT, 2,   32'hDEAD_BEEF);
        add_cmd(ple_pkg::OP_INSERT_AT, 1,   32'h0000_0000);
        add_cmd(ple_pkg::OP_INS_TAIL,  0,   32'hFFFF_FFFF);
        add_cmd(ple_pkg::OP_INS_HEAD,  255, 32'hA5A5_A5A5);
        add_cmd(ple_pkg::OP_INSERT_AT, 4,   32'h1234_5678);
        add_cmd(ple_pkg::OP_INSERT_AT, 255, 32'h0);
        add_cmd(ple_pkg::OP_READ_AT,   0,   32'h0);
        add_cmd(ple_pkg::OP_READ_AT,   5,   32'h0);
        add_cmd(ple_pkg::OP_READ_AT,   4,   32'h0);
        add_cmd(ple_pkg::OP_READ_AT,   1,   32'h0);
        add_cmd(ple_pkg::OP_LOCATE,    0,   32'hFFFF_FFFF);
        add_cmd(ple_pkg::OP_LOCATE,    0,   32'h0000_0000);
        add_cmd(ple_pkg::OP_LOCATE,    0,   32'h5555_5555);
        add_cmd(ple_pkg::OP_INS_TAIL,  0,   32'h0000_0000);
        add_cmd(ple_pkg::OP_LOCATE,    255, 32'h0000_0000);
        add_cmd(ple_pkg::OP_DELETE_AT, 5,   32'h0);
        add_cmd(ple_pkg::OP_DELETE_AT, 1,   32'h0);
        add_cmd(OP_UNUSED,             255, 32'hFFFF_FFFF);
        add_cmd(ple_pkg::OP_DELETE_AT, 0,   32'h0);
        add_cmd(ple_pkg::OP_CLEAR,     0,   32'h0);

        // random: phases that grow, shrink or churn the list
        phase = 0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 60 == 0)
                phase = $urandom_range(0, 2);
            ins_w = (phase == 0) ? 60 : (phase == 1) ? 15 : 35;
            del_w = (phase == 0) ? 10 : (phase == 1) ? 45 : 20;
            pick = $urandom_range(0, 99);
            if (pick < ins_w) begin
                case ($urandom_range(0, 3))
                    0: op = ple_pkg::OP_INS_HEAD;
                    1: op = ple_pkg::OP_INS_TAIL;
                    default: op = ple_pkg::OP_INSERT_AT;
                endcase
            end else if (pick < ins_w + del_w) begin
                op = ple_pkg::OP_DELETE_AT;
            end else if (pick < 97) begin
                op = ($urandom_range(0, 1) == 0) ? ple_pkg::OP_READ_AT : ple_pkg::OP_LOCATE;
            end else if (pick < 99) begin
                op = OP_UNUSED;
            end else begin
                op = ple_pkg::OP_CLEAR;
            end

            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                pos = $urandom_range(0, gen_len + 2);
            end else if (pick < 9) begin
                case ($urandom_range(0, 4))
                    0: pos = 0;
                    1: pos = 1;
                    2: pos = gen_len;
                    3: pos = gen_len + 1;
                    default: pos = gen_len + 2;
                endcase
            end else begin
                pos = $urandom_range(0, 255);
            end

            // pool values make locate hits and duplicate entries common
            if ($urandom_range(0, 9) < ((op == ple_pkg::OP_LOCATE) ? 7 : 5))
                val = value_pool[$urandom_range(0, 7)];
            else
                val = $urandom;
            add_cmd(op, pos, val);
        end
        total_items = pending_cmds.size();

        @(posedge i_rst_n);
        while (items_accepted < total_items || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (CAPACITY + 8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("positional_list_engine test passed");
        else
            $display("positional_list_engine test failed");
        $finish;
    end

endmodule
